// ===== rtl/sti_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, result codes and inter-stage types of the segment/triangle intersect unit.
// No dependencies.
package sti_pkg;
    localparam int COORD_WIDTH = 16;
    localparam int COORD_FRAC  = 8;
    localparam int T_FRAC      = 16;
    localparam int PTW   = 3 * COORD_WIDTH;
    localparam int DW    = COORD_WIDTH + 1;
    localparam int CMW   = 2 * DW;
    localparam int CPW   = CMW + 1;
    localparam int DPW   = CPW + DW;
    localparam int DOTW  = DPW + 2;
    localparam int QW    = COORD_WIDTH + 2 + T_FRAC;
    localparam int NUMW  = DOTW + T_FRAC;
    localparam int TQW   = QW + 2;
    localparam int PW    = DW + TQW;
    localparam int SUMW  = PW + 2 - T_FRAC;

    localparam logic [1:0] OUT_HIT     = 2'd0;
    localparam logic [1:0] OUT_PAR     = 2'd1;
    localparam logic [1:0] OUT_OUTSIDE = 2'd2;
    localparam logic [1:0] OUT_BEYOND  = 2'd3;

    typedef struct packed {
        logic signed [2:0][DW-1:0]          d;
        logic signed [2:0][COORD_WIDTH-1:0] st;
    } t_side;

    typedef struct packed {
        logic signed [DOTW-1:0] det;
        logic signed [DOTW-1:0] u;
        logic signed [DOTW-1:0] w;
        logic signed [DOTW-1:0] n;
    } t_dots;

    typedef struct packed {
        logic par;
        logic outside;
        logic neg;
        logic ovf;
    } t_cls;
endpackage

// ===== rtl/sti_geom.sv =====
`timescale 1ns / 1ps
// Front end: edge vectors, cross products and the four dot products (five stages).
// Depends on sti_pkg.
module sti_geom
    import sti_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [PTW-1:0]  i_seg_start,
    input  logic [PTW-1:0]  i_seg_end,
    input  logic [PTW-1:0]  i_tri_a,
    input  logic [PTW-1:0]  i_tri_b,
    input  logic [PTW-1:0]  i_tri_c,
    output logic            o_valid,
    output t_dots           o_dots,
    output t_side           o_side
);
    logic [4:0] r_v;
    logic signed [DW-1:0]          r_d1 [3], r_e1a [3], r_e2a [3], r_sa [3];
    logic signed [COORD_WIDTH-1:0] r_st1 [3];
    logic signed [CMW-1:0] r_pm [3][2];
    logic signed [CMW-1:0] r_qm [3][2];
    logic signed [DW-1:0]  r_d2 [3], r_e1b [3], r_e2b [3], r_sb [3];
    logic signed [COORD_WIDTH-1:0] r_st2 [3];
    logic signed [CPW-1:0] r_p [3], r_q [3];
    logic signed [DW-1:0]  r_e1c [3], r_e2c [3], r_sc [3];
    t_side r_side3, r_side4, r_side5;
    logic signed [DPW-1:0] r_m [4][3];
    t_dots r_dots;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                logic signed [DW-1:0] a, b, c, st, en;
                a  = DW'($signed(i_tri_a[i*COORD_WIDTH +: COORD_WIDTH]));
                b  = DW'($signed(i_tri_b[i*COORD_WIDTH +: COORD_WIDTH]));
                c  = DW'($signed(i_tri_c[i*COORD_WIDTH +: COORD_WIDTH]));
                st = DW'($signed(i_seg_start[i*COORD_WIDTH +: COORD_WIDTH]));
                en = DW'($signed(i_seg_end[i*COORD_WIDTH +: COORD_WIDTH]));
                r_d1[i]  <= en - st;
                r_e1a[i] <= b - a;
                r_e2a[i] <= c - a;
                r_sa[i]  <= st - a;
                r_st1[i] <= i_seg_start[i*COORD_WIDTH +: COORD_WIDTH];
            end
            // cross terms: p = d x e2, q = s x e1
            for (int i = 0; i < 3; i++) begin
                r_pm[i][0] <= r_d1[(i+1)%3] * r_e2a[(i+2)%3];
                r_pm[i][1] <= r_d1[(i+2)%3] * r_e2a[(i+1)%3];
                r_qm[i][0] <= r_sa[(i+1)%3] * r_e1a[(i+2)%3];
                r_qm[i][1] <= r_sa[(i+2)%3] * r_e1a[(i+1)%3];
            end
            r_d2 <= r_d1; r_e1b <= r_e1a; r_e2b <= r_e2a; r_sb <= r_sa; r_st2 <= r_st1;
            for (int i = 0; i < 3; i++) begin
                r_p[i] <= CPW'(r_pm[i][0]) - CPW'(r_pm[i][1]);
                r_q[i] <= CPW'(r_qm[i][0]) - CPW'(r_qm[i][1]);
                r_side3.d[i]  <= r_d2[i];
                r_side3.st[i] <= r_st2[i];
            end
            r_e1c <= r_e1b; r_e2c <= r_e2b; r_sc <= r_sb;
            for (int i = 0; i < 3; i++) begin
                r_m[0][i] <= r_p[i] * r_e1c[i];
                r_m[1][i] <= r_p[i] * r_sc[i];
                r_m[2][i] <= r_q[i] * $signed(r_side3.d[i]);
                r_m[3][i] <= r_q[i] * r_e2c[i];
            end
            r_side4 <= r_side3;
            r_dots.det <= DOTW'(r_m[0][0]) + DOTW'(r_m[0][1]) + DOTW'(r_m[0][2]);
            r_dots.u   <= DOTW'(r_m[1][0]) + DOTW'(r_m[1][1]) + DOTW'(r_m[1][2]);
            r_dots.w   <= DOTW'(r_m[2][0]) + DOTW'(r_m[2][1]) + DOTW'(r_m[2][2]);
            r_dots.n   <= DOTW'(r_m[3][0]) + DOTW'(r_m[3][1]) + DOTW'(r_m[3][2]);
            r_side5 <= r_side4;
        end
    end

    assign o_valid = r_v[4];
    assign o_dots  = r_dots;
    assign o_side  = r_side5;
endmodule

// ===== rtl/sti_div.sv =====
`timescale 1ns / 1ps
// Sign fold, barycentric tests and pipelined restoring divider for t (QW+2 stages).
// Depends on sti_pkg.
module sti_div
    import sti_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_dots            i_dots,
    input  t_side            i_side,
    output logic             o_valid,
    output t_cls             o_cls,
    output logic [QW-1:0]    o_q,
    output t_side            o_side
);
    typedef struct packed {
        logic [DOTW:0]   rem;
        logic [QW-1:0]   q;
        logic [QW-1:0]   nlo;
        logic [DOTW-1:0] det;
        t_cls            cls;
        t_side           side;
    } t_dstage;

    logic                   r_v1;
    logic [DOTW-1:0]        r_det;
    logic signed [DOTW-1:0] r_u, r_w;
    logic [DOTW-1:0]        r_nmag;
    logic                   r_nneg, r_par;
    t_side                  r_side1;

    logic                   r_vs [QW+1];
    t_dstage                r_st [QW+1];

    logic                   dneg;
    logic signed [DOTW-1:0] n_u, n_w, n_n;
    logic [NUMW-1:0]        num;
    logic signed [DOTW:0]   uw;
    t_dstage                n_st0;

    always_comb begin
        dneg = i_dots.det[DOTW-1];
        n_u  = dneg ? -i_dots.u : i_dots.u;
        n_w  = dneg ? -i_dots.w : i_dots.w;
        n_n  = dneg ? -i_dots.n : i_dots.n;
    end

    always_comb begin
        num = {r_nmag, {T_FRAC{1'b0}}};
        uw  = (DOTW+1)'(r_u) + (DOTW+1)'(r_w);
        n_st0.rem  = (DOTW+1)'(num[NUMW-1:QW]);
        n_st0.q    = '0;
        n_st0.nlo  = num[QW-1:0];
        n_st0.det  = r_det;
        n_st0.cls.par     = r_par;
        n_st0.cls.outside = r_u[DOTW-1] | r_w[DOTW-1] | (uw > $signed({1'b0, r_det}));
        n_st0.cls.neg     = r_nneg;
        n_st0.cls.ovf     = (DOTW+1)'(num[NUMW-1:QW]) >= {1'b0, r_det};
        n_st0.side = r_side1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_vs[0]  <= 1'b0;
        end else if (i_en) begin
            r_v1     <= i_valid;
            r_vs[0]  <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det   <= dneg ? DOTW'(-i_dots.det) : DOTW'(i_dots.det);
            r_par   <= (i_dots.det == '0);
            r_u     <= n_u;
            r_w     <= n_w;
            r_nneg  <= n_n[DOTW-1];
            r_nmag  <= n_n[DOTW-1] ? DOTW'(-n_n) : DOTW'(n_n);
            r_side1 <= i_side;
            r_st[0] <= n_st0;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DOTW:0] sh;
        logic          ge;
        t_dstage       n_nx;
        always_comb begin
            sh   = {r_st[k].rem[DOTW-1:0], r_st[k].nlo[QW-1]};
            ge   = sh >= {1'b0, r_st[k].det};
            n_nx = r_st[k];
            n_nx.rem = ge ? sh - {1'b0, r_st[k].det} : sh;
            n_nx.q   = {r_st[k].q[QW-2:0], ge};
            n_nx.nlo = {r_st[k].nlo[QW-2:0], 1'b0};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vs[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vs[k+1] <= r_vs[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k+1] <= n_nx;
            end
        end
    end

    assign o_valid = r_vs[QW];
    assign o_cls   = r_st[QW].cls;
    assign o_q     = r_st[QW].q;
    assign o_side  = r_st[QW].side;
endmodule

// ===== rtl/sti_point.sv =====
`timescale 1ns / 1ps
// Back end: signed t, outcome, point = start + d*t with truncation and saturation (3 stages).
// Depends on sti_pkg.
module sti_point
    import sti_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  t_cls                          i_cls,
    input  logic [QW-1:0]                 i_q,
    input  t_side                         i_side,
    output logic                          o_valid,
    output logic [1:0]                    o_outcome,
    output logic signed [COORD_WIDTH-1:0] o_x,
    output logic signed [COORD_WIDTH-1:0] o_y,
    output logic signed [COORD_WIDTH-1:0] o_z
);
    localparam logic signed [SUMW-1:0] CMAX = SUMW'((1 << (COORD_WIDTH-1)) - 1);
    localparam logic signed [SUMW-1:0] CMIN = -SUMW'(1 << (COORD_WIDTH-1));

    logic [2:0] r_v;
    logic signed [TQW-1:0] r_tq;
    logic [1:0]  r_oc1, r_oc2, r_oc3;
    logic        r_zero1, r_zero2;
    t_side       r_side1;
    logic signed [COORD_WIDTH-1:0] r_st2 [3];
    logic signed [PW-1:0]          r_prod [3];
    logic signed [COORD_WIDTH-1:0] r_pt [3];

    logic [TQW-1:0]        mag;
    logic signed [TQW-1:0] tq;
    logic                  beyond;
    logic [1:0]            n_oc;
    logic signed [PW:0]    adj [3];
    logic signed [SUMW-1:0] sum [3];
    logic signed [COORD_WIDTH-1:0] n_pt [3];

    always_comb begin
        mag    = i_cls.ovf ? (TQW'(1) << QW) : TQW'(i_q);
        tq     = i_cls.neg ? -$signed(mag) : $signed(mag);
        beyond = !((tq > 0) && (tq < $signed(TQW'(1) << T_FRAC)));
        if (i_cls.par)          n_oc = OUT_PAR;
        else if (i_cls.outside) n_oc = OUT_OUTSIDE;
        else if (beyond)        n_oc = OUT_BEYOND;
        else                    n_oc = OUT_HIT;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // truncate toward zero
            adj[i] = r_prod[i][PW-1] ? (PW+1)'(r_prod[i]) + (PW+1)'((1 << T_FRAC) - 1)
                                     : (PW+1)'(r_prod[i]);
            sum[i] = SUMW'(r_st2[i]) + SUMW'(adj[i] >>> T_FRAC);
            if (r_zero2)           n_pt[i] = '0;
            else if (sum[i] > CMAX) n_pt[i] = CMAX[COORD_WIDTH-1:0];
            else if (sum[i] < CMIN) n_pt[i] = CMIN[COORD_WIDTH-1:0];
            else                   n_pt[i] = sum[i][COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tq    <= tq;
            r_oc1   <= n_oc;
            r_zero1 <= i_cls.par | i_cls.outside;
            r_side1 <= i_side;
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= $signed(r_side1.d[i]) * r_tq;
                r_st2[i]  <= r_side1.st[i];
            end
            r_oc2   <= r_oc1;
            r_zero2 <= r_zero1;
            r_pt    <= n_pt;
            r_oc3   <= r_oc2;
        end
    end

    assign o_valid   = r_v[2];
    assign o_outcome = r_oc3;
    assign o_x       = r_pt[0];
    assign o_y       = r_pt[1];
    assign o_z       = r_pt[2];
endmodule

// ===== rtl/segment_triangle_intersect_unit.sv =====
`timescale 1ns / 1ps
// Segment/triangle intersection unit, exact fixed-point Moller-Trumbore.
// Top level; depends on sti_pkg, sti_geom, sti_div, sti_point.
//
// Usage:
//  Input channel (i_in_valid / o_in_ready) takes one word: segment start/end and
//  three triangle corners, each x/y/z signed Q8.8 packed in 48 bits.
//  Output channel (o_out_valid / i_out_ready) gives one word per input word, in
//  order: o_hit, o_outcome (hit, parallel, outside, beyond ends) and the point.
//  Pipeline: 5 geometry stages, 36 divider stages (sign fold,
//  classify, one quotient bit per stage for 34 bits), 3 point stages.
//  Throughput: one word per clock unless stalled; 34 quotient stages set depth.
//  A stalled receiver freezes the whole pipeline, output register included;
//  o_in_ready is low only while a result waits and i_out_ready is low.
//  Reset (i_rst_n low at a clock edge) empties the pipeline; no results remain.
module segment_triangle_intersect_unit
    import sti_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [PTW-1:0]                i_seg_start,
    input  logic [PTW-1:0]                i_seg_end,
    input  logic [PTW-1:0]                i_tri_a,
    input  logic [PTW-1:0]                i_tri_b,
    input  logic [PTW-1:0]                i_tri_c,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_hit,
    output logic [1:0]                    o_outcome,
    output logic signed [COORD_WIDTH-1:0] o_hit_x,
    output logic signed [COORD_WIDTH-1:0] o_hit_y,
    output logic signed [COORD_WIDTH-1:0] o_hit_z
);
    logic          en;
    logic          g_valid, d_valid;
    t_dots         g_dots;
    t_side         g_side, d_side;
    t_cls          d_cls;
    logic [QW-1:0] d_q;

    assign en         = !o_out_valid | i_out_ready;
    assign o_in_ready = en;

    sti_geom u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_in_valid),
        .i_seg_start (i_seg_start),
        .i_seg_end   (i_seg_end),
        .i_tri_a     (i_tri_a),
        .i_tri_b     (i_tri_b),
        .i_tri_c     (i_tri_c),
        .o_valid     (g_valid),
        .o_dots      (g_dots),
        .o_side      (g_side)
    );

    sti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (g_valid),
        .i_dots  (g_dots),
        .i_side  (g_side),
        .o_valid (d_valid),
        .o_cls   (d_cls),
        .o_q     (d_q),
        .o_side  (d_side)
    );

    sti_point u_point (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (d_valid),
        .i_cls     (d_cls),
        .i_q       (d_q),
        .i_side    (d_side),
        .o_valid   (o_out_valid),
        .o_outcome (o_outcome),
        .o_x       (o_hit_x),
        .o_y       (o_hit_y),
        .o_z       (o_hit_z)
    );

    assign o_hit = (o_outcome == OUT_HIT);
endmodule
